// ===== src/erlm_pkg.sv =====
// Shared types and constants for the emergency reason latch monitor.
// Depends on nothing; every other file in src imports it.
package erlm_pkg;

	// Command codes carried on the command field of a request.
	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_MSG     = 3'd1;
	localparam logic [2:0] CMD_INPUT   = 3'd2;
	localparam logic [2:0] CMD_HEALTH  = 3'd3;
	localparam logic [2:0] CMD_REQUIRE = 3'd4;
	localparam logic [2:0] CMD_STOP    = 3'd5;

	// Configuration register indexes.
	localparam logic [2:0] REG_LATCH_MASK    = 3'd0;
	localparam logic [2:0] REG_INPUT_MASK    = 3'd1;
	localparam logic [2:0] REG_TIMEOUT_CLEAR = 3'd2;
	localparam logic [2:0] REG_HB_BIT        = 3'd3;
	localparam logic [2:0] REG_NOT_READY_BIT = 3'd4;
	localparam logic [2:0] REG_HB_TIMEOUT    = 3'd5;
	localparam logic [2:0] REG_LOST_DELAY    = 3'd6;

	// Latch and link event codes.
	localparam logic [1:0] LATCH_NONE  = 2'd0;
	localparam logic [1:0] LATCH_ENTER = 2'd1;
	localparam logic [1:0] LATCH_LEAVE = 2'd2;
	localparam logic [1:0] LINK_NONE   = 2'd0;
	localparam logic [1:0] LINK_CONN   = 2'd1;
	localparam logic [1:0] LINK_LOST   = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [15:0] RST_LATCH_MASK    = 16'd1;
	localparam logic [15:0] RST_INPUT_MASK    = 16'd62;
	localparam logic [15:0] RST_TIMEOUT_CLEAR = 16'd192;
	localparam logic [15:0] RST_HB_BIT        = 16'd64;
	localparam logic [15:0] RST_NOT_READY_BIT = 16'd256;
	localparam logic [31:0] RST_HB_TIMEOUT    = 32'd1000000;
	localparam logic [31:0] RST_LOST_DELAY    = 32'd2000000;
	localparam logic [31:0] RST_LOST_AT       = 32'd3000000;

	localparam logic [31:0] WAKE_NONE  = 32'hFFFF_FFFF;
	localparam logic [31:0] RECHECK_US = 32'd100000;

	// Decoded command class; all zero for unused codes.
	typedef struct packed {
		logic tick;
		logic msg;
		logic inp;
		logic health;
		logic require;
		logic stop;
	} cls_t;

	// One classified request as it sits in the queue.
	typedef struct packed {
		cls_t        cls;
		logic [31:0] now_us;
		logic [15:0] add_bits;
		logic [15:0] clear_bits;
		logic        svc_ready;
	} item_t;

	// Configuration as seen by the back end.
	typedef struct packed {
		logic [15:0] latch_mask;
		logic [15:0] input_mask;
		logic [15:0] timeout_clear;
		logic [15:0] hb_bit;
		logic [15:0] not_ready_bit;
		logic [31:0] hb_timeout_us;
		logic [31:0] lost_at_us;
	} cfg_t;

endpackage

// ===== src/erlm_front.sv =====
// Front end of the emergency reason latch monitor: request handshake and
// command classification. Depends on erlm_pkg.
module erlm_front
	import erlm_pkg::*;
(
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [31:0] now_us,
	input  logic [15:0] add_bits,
	input  logic [15:0] clear_bits,
	input  logic        svc_ready,
	input  logic        q_full,
	output logic        push,
	output item_t       push_item
);

	cls_t cls;

	// Turn the command code into one class flag.
	always_comb begin
		cls = '0;
		unique case (command)
			CMD_TICK:    cls.tick    = 1'b1;
			CMD_MSG:     cls.msg     = 1'b1;
			CMD_INPUT:   cls.inp     = 1'b1;
			CMD_HEALTH:  cls.health  = 1'b1;
			CMD_REQUIRE: cls.require = 1'b1;
			CMD_STOP:    cls.stop    = 1'b1;
			default:     cls = '0;
		endcase
	end

	// A request is taken whenever the queue has room.
	assign in_ready = ~q_full;
	assign push     = in_valid & ~q_full;

	assign push_item.cls        = cls;
	assign push_item.now_us     = now_us;
	assign push_item.add_bits   = add_bits;
	assign push_item.clear_bits = clear_bits;
	assign push_item.svc_ready  = svc_ready;

endmodule

// ===== src/erlm_queue.sv =====
// Short queue between the front and back ends of the monitor.
// Depends on erlm_pkg for the item type.
module erlm_queue
	import erlm_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output logic  full,
	output logic  head_valid,
	output item_t head_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	// Storage is written at the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/erlm_back.sv =====
// Back end of the monitor: holds the reason word and heartbeat state,
// applies one queued request per cycle while the result register is empty or
// being taken by the receiver, and drives that register. Depends on erlm_pkg.
module erlm_back
	import erlm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        head_valid,
	input  item_t       head_item,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] reasons,
	output logic [15:0] changed_bits,
	output logic        status_send,
	output logic [1:0]  latch_event,
	output logic [1:0]  link_event,
	output logic [31:0] wake_after_us
);

	logic [15:0] reason_q;
	logic [31:0] last_hb_q;
	logic        seen_q;
	logic [1:0]  link_q;
	logic        svc_req_q;

	logic        out_valid_q;
	logic [15:0] reasons_q;
	logic [15:0] changed_q;
	logic        send_q;
	logic [1:0]  latch_q;
	logic [1:0]  link_ev_q;
	logic [31:0] wake_q;

	logic [31:0] age;
	logic        timed_out;
	logic        reached_lost;
	logic [31:0] to_wake;
	logic [31:0] lost_wake;
	logic        do_update;
	logic [15:0] add_m;
	logic [15:0] clr_m;
	logic [15:0] new_word;
	logic [15:0] changed;
	logic        send;
	logic        latch_before;
	logic        latch_after;
	logic [1:0]  latch_ev;
	logic [1:0]  link_ev;
	logic [1:0]  link_next;
	logic [31:0] wake;
	item_t       it;

	assign it  = head_item;
	assign pop = head_valid & (~out_valid_q | out_ready);

	// Heartbeat age and the two deadlines it is measured against.
	assign age          = it.now_us - last_hb_q;
	assign timed_out    = (age >= cfg.hb_timeout_us);
	assign reached_lost = (age >= cfg.lost_at_us);
	assign to_wake      = cfg.hb_timeout_us - age;
	assign lost_wake    = cfg.lost_at_us - age;

	// Masks of the clear-then-set step for each command class but require.
	always_comb begin
		do_update = 1'b0;
		add_m     = '0;
		clr_m     = '0;
		priority if (it.cls.tick) begin
			do_update = 1'b1;
			add_m     = timed_out ? cfg.hb_bit : 16'd0;
			clr_m     = cfg.timeout_clear;
		end else if (it.cls.msg) begin
			do_update = 1'b1;
			add_m     = it.add_bits;
			clr_m     = it.clear_bits & ~cfg.not_ready_bit;
		end else if (it.cls.inp) begin
			do_update = 1'b1;
			add_m     = it.add_bits;
			clr_m     = cfg.input_mask;
		end else if (it.cls.health) begin
			do_update = svc_req_q;
			add_m     = it.svc_ready ? 16'd0 : cfg.not_ready_bit;
			clr_m     = cfg.not_ready_bit;
		end else if (it.cls.stop) begin
			do_update = 1'b1;
			add_m     = cfg.hb_bit;
			clr_m     = '0;
		end else begin
			do_update = 1'b0;
		end
	end

	// New reason word; the require command sets the not-ready bit directly.
	always_comb begin
		if (do_update) begin
			new_word = (reason_q & ~clr_m) | add_m;
		end else if (it.cls.require) begin
			new_word = reason_q | cfg.not_ready_bit;
		end else begin
			new_word = reason_q;
		end
	end

	assign changed      = reason_q ^ new_word;
	assign send         = do_update & (changed != '0);
	assign latch_before = (reason_q & cfg.latch_mask) != '0;
	assign latch_after  = (new_word & cfg.latch_mask) != '0;

	always_comb begin
		latch_ev = LATCH_NONE;
		if (send && latch_after && !latch_before) begin
			latch_ev = LATCH_ENTER;
		end else if (send && !latch_after && latch_before) begin
			latch_ev = LATCH_LEAVE;
		end
	end

	// Link announcements and wake time.
	always_comb begin
		link_ev   = LINK_NONE;
		link_next = link_q;
		wake      = WAKE_NONE;
		if (it.cls.tick) begin
			if (!timed_out) begin
				wake = to_wake;
			end
			if (seen_q) begin
				if (!timed_out) begin
					if (((changed & cfg.hb_bit) != '0) && (link_q != LINK_CONN)) begin
						link_ev   = LINK_CONN;
						link_next = LINK_CONN;
					end
				end else if (link_q != LINK_LOST) begin
					if (reached_lost) begin
						link_ev   = LINK_LOST;
						link_next = LINK_LOST;
					end else if (lost_wake < wake) begin
						wake = lost_wake;
					end
				end
			end
		end else if (it.cls.health && svc_req_q) begin
			wake = it.svc_ready ? WAKE_NONE : RECHECK_US;
		end
	end

	// Monitor state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reason_q  <= RST_HB_BIT;
			last_hb_q <= '0;
			seen_q    <= 1'b0;
			link_q    <= LINK_NONE;
			svc_req_q <= 1'b0;
		end else if (pop) begin
			reason_q <= new_word;
			link_q   <= link_next;
			if (it.cls.msg) begin
				last_hb_q <= it.now_us;
				seen_q    <= 1'b1;
			end
			if (it.cls.require) begin
				svc_req_q <= 1'b1;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			reasons_q <= new_word;
			changed_q <= changed;
			send_q    <= send;
			latch_q   <= latch_ev;
			link_ev_q <= link_ev;
			wake_q    <= wake;
		end
	end

	assign out_valid     = out_valid_q;
	assign reasons       = reasons_q;
	assign changed_bits  = changed_q;
	assign status_send   = send_q;
	assign latch_event   = latch_q;
	assign link_event    = link_ev_q;
	assign wake_after_us = wake_q;

endmodule

// ===== src/emergency_reason_latch_monitor_top.sv =====
// Top level of the emergency reason latch monitor: configuration registers
// and the front end, queue and back end. Depends on erlm_pkg and the erlm_* modules.
//
// Usage: each request on the input channel (in_valid/in_ready) carries one
// event: tick, heartbeat message, input reasons, service health, require
// service or stop. Every request yields exactly one result on the output
// channel (out_valid/out_ready) with the reason word, the changed bits, the
// status-send flag, latch and link events and the wake time.
// When the queue is empty, an accepted request is first written into the queue
// and the back end then loads the result register from its head. The back end
// applies one event per cycle to the reason word, so one request per cycle
// goes through while the receiver takes each result.
// When the receiver stalls, the result register holds and the queue of
// QUEUE_DEPTH entries keeps taking requests until it is full; then in_ready
// drops. The user writes configuration through cfg_wr_en/cfg_index/cfg_data
// only while no request is in flight; the block itself does not enforce it.
// Reset restores every configuration register and sets the reason word to
// the heartbeat timeout bit; no clearing pass.
module emergency_reason_latch_monitor_top
	import erlm_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [31:0] now_us,
	input  logic [15:0] add_bits,
	input  logic [15:0] clear_bits,
	input  logic        svc_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] reasons,
	output logic [15:0] changed_bits,
	output logic        status_send,
	output logic [1:0]  latch_event,
	output logic [1:0]  link_event,
	output logic [31:0] wake_after_us
);

	cfg_t        cfg_q;
	logic [31:0] lost_delay_q;
	logic [32:0] lost_sum;
	logic [31:0] lost_at;

	logic        q_full;
	logic        push;
	item_t       push_item;
	logic        pop;
	logic        head_valid;
	item_t       head_item;

	// Timeout plus lost delay, saturating, formed with the value being written.
	always_comb begin
		if (cfg_index == REG_HB_TIMEOUT) begin
			lost_sum = {1'b0, cfg_data} + {1'b0, lost_delay_q};
		end else begin
			lost_sum = {1'b0, cfg_q.hb_timeout_us} + {1'b0, cfg_data};
		end
		lost_at = lost_sum[32] ? WAKE_NONE : lost_sum[31:0];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.latch_mask    <= RST_LATCH_MASK;
			cfg_q.input_mask    <= RST_INPUT_MASK;
			cfg_q.timeout_clear <= RST_TIMEOUT_CLEAR;
			cfg_q.hb_bit        <= RST_HB_BIT;
			cfg_q.not_ready_bit <= RST_NOT_READY_BIT;
			cfg_q.hb_timeout_us <= RST_HB_TIMEOUT;
			cfg_q.lost_at_us    <= RST_LOST_AT;
			lost_delay_q        <= RST_LOST_DELAY;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LATCH_MASK:    cfg_q.latch_mask    <= cfg_data[15:0];
				REG_INPUT_MASK:    cfg_q.input_mask    <= cfg_data[15:0];
				REG_TIMEOUT_CLEAR: cfg_q.timeout_clear <= cfg_data[15:0];
				REG_HB_BIT:        cfg_q.hb_bit        <= cfg_data[15:0];
				REG_NOT_READY_BIT: cfg_q.not_ready_bit <= cfg_data[15:0];
				REG_HB_TIMEOUT: begin
					cfg_q.hb_timeout_us <= cfg_data;
					cfg_q.lost_at_us    <= lost_at;
				end
				REG_LOST_DELAY: begin
					lost_delay_q     <= cfg_data;
					cfg_q.lost_at_us <= lost_at;
				end
				default: ;
			endcase
		end
	end

	erlm_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.now_us     (now_us),
		.add_bits   (add_bits),
		.clear_bits (clear_bits),
		.svc_ready  (svc_ready),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	erlm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	erlm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.reasons       (reasons),
		.changed_bits  (changed_bits),
		.status_send   (status_send),
		.latch_event   (latch_event),
		.link_event    (link_event),
		.wake_after_us (wake_after_us)
	);

endmodule
